FILE: design/hhtb_pkg.sv
// Shared types, constants and codes of the Huffman header tree builder.
package hhtb_pkg;

    localparam int DEF_MAX_NODES   = 512;
    localparam int DEF_STACK_DEPTH = 256;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 9;
    localparam int VAL_W  = 16;
    localparam int STAT_W = 3;
    localparam int BITS_W = 4;
    localparam int POS_W  = 3;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);

    localparam logic [BYTE_W-1:0] CHAR_ONE  = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BITS_W-1:0] SYM_BITS  = 4'd8;
    localparam logic [POS_W-1:0]  POS_MSB   = 3'd7;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_LEFTOVER   = 3'd3,
        ST_UNDERFLOW  = 3'd4,
        ST_OVERFLOW   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        K_END  = 2'd0,
        K_TEXT = 2'd1,
        K_BIN  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_input;
    } t_item;

    typedef struct packed {
        logic              node_valid;
        logic [IDX_W-1:0]  node_index;
        logic              is_leaf;
        logic [VAL_W-1:0]  node_value;
        logic [IDX_W-1:0]  left_child;
        logic [IDX_W-1:0]  right_child;
        logic              header_done;
        logic [IDX_W-1:0]  root_index;
        logic [STAT_W-1:0] status;
        logic              last_result;
    } t_result;

    // Classified header word as it travels from the front to the back.
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] byte_value;
        logic              is_one;
        logic              is_zero;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } t_entry;

endpackage

FILE: design/huffman_header_tree_builder.sv
// Top level of the Huffman header tree builder.
// Rebuilds a Huffman tree from a post-order header, one header byte per
// input word, and reports every created node and a final root/status word.
// Words are accepted back to back while the four-entry command queue is not
// full; the back end handles a text character or an end-of-stream word as a
// single step and a binary byte one header bit at a time, dropping the rest of
// the byte when the header finishes inside it, with at most one stack
// operation per cycle and no step while the result queue is full. A result
// word is held in a pending register until the next result or the end of its
// input word is seen, and leaves through a four-entry result queue. The node
// stack keeps its top two entries in registers and the rest in a
// single-port-write memory, so no clearing pass is needed after reset.
module huffman_header_tree_builder #(
    parameter int MAX_NODES   = hhtb_pkg::DEF_MAX_NODES,
    parameter int STACK_DEPTH = hhtb_pkg::DEF_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  hhtb_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output hhtb_pkg::t_result o_result,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data
);
    import hhtb_pkg::*;

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    logic    res_push;
    t_result res_data;
    logic    res_full;

    hhtb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    hhtb_back #(
        .MAX_NODES   (MAX_NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res_data  (res_data),
        .i_res_full  (res_full)
    );

    hhtb_res_fifo u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (res_data),
        .o_full    (res_full),
        .empty     (empty),
        .pop       (pop),
        .o_rd_data (o_result)
    );

endmodule

FILE: design/hhtb_front.sv
// Front part: format register, word classification and command queue.
module hhtb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  hhtb_pkg::t_item i_item,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    output logic           o_cmd_valid,
    output hhtb_pkg::t_cmd o_cmd,
    input  logic           i_cmd_pop
);
    import hhtb_pkg::*;

    logic                 r_header_format;
    t_cmd                 r_queue [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_PTR_W:0]   r_count, n_count;
    logic                 accept;
    logic                 take;
    t_cmd                 cmd_in;

    assign full        = (r_count == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign accept      = push && !full;
    assign take        = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cmd_in.byte_value = i_item.byte_value;
        cmd_in.is_one     = (i_item.byte_value == CHAR_ONE);
        cmd_in.is_zero    = (i_item.byte_value == CHAR_ZERO);
        if (i_item.end_of_input) begin
            cmd_in.kind = K_END;
        end else if (r_header_format) begin
            cmd_in.kind = K_BIN;
        end else begin
            cmd_in.kind = K_TEXT;
        end
    end

    always_comb begin
        n_wr_ptr = accept ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = take ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (accept && !take) begin
            n_count = r_count + 1'b1;
        end else if (take && !accept) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_format <= 1'b0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_header_format <= i_cfg_wr_data;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

FILE: design/hhtb_res_fifo.sv
// Result queue that holds finished result words until they are popped.
module hhtb_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  hhtb_pkg::t_result i_wr_data,
    output logic              o_full,
    output logic              empty,
    input  logic              pop,
    output hhtb_pkg::t_result o_rd_data
);
    import hhtb_pkg::*;

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_PTR_W:0]   r_count, n_count;
    logic                 wr;
    logic                 rd;

    assign o_full    = (r_count == (RES_PTR_W+1)'(RES_DEPTH));
    assign empty     = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr        = i_wr_en && !o_full;
    assign rd        = pop && !empty;

    always_comb begin
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: design/hhtb_back.sv
// Back part: bit sequencer, node stack and result staging.
module hhtb_back #(
    parameter int MAX_NODES   = hhtb_pkg::DEF_MAX_NODES,
    parameter int STACK_DEPTH = hhtb_pkg::DEF_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  hhtb_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output hhtb_pkg::t_result o_res_data,
    input  logic              i_res_full
);
    import hhtb_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int NODE_W = $clog2(MAX_NODES + 1);

    // The two top entries live in registers; the rest of the stack is in memory.
    t_entry              r_mem [STACK_DEPTH];
    t_entry              r_mem_q;
    t_entry              r_top0, n_top0;
    t_entry              r_top1, n_top1;
    t_entry              r_fwd, n_fwd;
    logic                r_third_sel, n_third_sel;
    t_entry              third;

    logic [CNT_W-1:0]    r_count, n_count;
    logic [NODE_W-1:0]   r_next_node, n_next_node;
    logic [BITS_W-1:0]   r_bits_left, n_bits_left;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic                r_finished, n_finished;
    logic [POS_W-1:0]    r_pos, n_pos;

    t_result             r_pend, n_pend;
    logic                r_pend_v, n_pend_v;
    logic                r_pend_last, n_pend_last;

    logic                step_en;
    logic                step_last;
    logic                gen;
    t_result             gen_res;
    logic                do_push;
    logic                do_comb;
    logic                do_end;
    logic [BYTE_W-1:0]   push_sym;
    logic [BYTE_W-1:0]   shifted;
    logic                cur_bit;
    logic                stack_full;
    logic                nodes_full;
    logic [VAL_W:0]      sum_wide;
    logic [VAL_W-1:0]    sum;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    function automatic t_result make_node(logic [IDX_W-1:0] idx, logic leaf,
                                          logic [VAL_W-1:0] val,
                                          logic [IDX_W-1:0] left,
                                          logic [IDX_W-1:0] right);
        t_result res;
        res             = '0;
        res.node_valid  = 1'b1;
        res.node_index  = idx;
        res.is_leaf     = leaf;
        res.node_value  = val;
        res.left_child  = left;
        res.right_child = right;
        return res;
    endfunction

    function automatic t_result make_done(logic [IDX_W-1:0] root, t_status st);
        t_result res;
        res             = '0;
        res.header_done = 1'b1;
        res.root_index  = root;
        res.status      = st;
        return res;
    endfunction

    assign third      = r_third_sel ? r_mem_q : r_fwd;
    assign step_en    = i_cmd_valid && !i_res_full;
    assign stack_full = (r_count == CNT_W'(STACK_DEPTH));
    assign nodes_full = (r_next_node == NODE_W'(MAX_NODES));
    assign sum_wide   = {1'b0, r_top0.val} + {1'b0, r_top1.val};
    assign sum        = sum_wide[VAL_W] ? {VAL_W{1'b1}} : sum_wide[VAL_W-1:0];
    assign cur_bit    = i_cmd.byte_value[r_pos];
    assign shifted    = {r_shift[BYTE_W-2:0], cur_bit};
    assign o_cmd_pop  = step_en && step_last;

    always_comb begin
        n_top0      = r_top0;
        n_top1      = r_top1;
        n_fwd       = r_fwd;
        n_third_sel = r_third_sel;
        n_count     = r_count;
        n_next_node = r_next_node;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_finished  = r_finished;
        n_pos       = r_pos;
        step_last   = 1'b1;
        gen         = 1'b0;
        gen_res     = '0;
        do_push     = 1'b0;
        do_comb     = 1'b0;
        do_end      = 1'b0;
        push_sym    = '0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_count - CNT_W'(2));
        mem_wdata   = r_top1;
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_count - CNT_W'(4));

        if (step_en && !r_finished) begin
            case (i_cmd.kind)
                K_END: begin
                    do_end = 1'b1;
                end
                K_TEXT: begin
                    if (r_bits_left != '0) begin
                        n_bits_left = '0;
                        n_shift     = '0;
                        do_push     = 1'b1;
                        push_sym    = i_cmd.byte_value;
                    end else if (i_cmd.is_one) begin
                        n_bits_left = BITS_W'(1);
                    end else if (i_cmd.is_zero) begin
                        do_comb = 1'b1;
                    end
                end
                K_BIN: begin
                    step_last = (r_pos == '0);
                    if (r_bits_left != '0) begin
                        n_bits_left = r_bits_left - 1'b1;
                        if (r_bits_left == BITS_W'(1)) begin
                            n_shift  = '0;
                            do_push  = 1'b1;
                            push_sym = shifted;
                        end else begin
                            n_shift = shifted;
                        end
                    end else if (cur_bit) begin
                        n_bits_left = SYM_BITS;
                        n_shift     = '0;
                    end else begin
                        do_comb = 1'b1;
                    end
                end
                default: begin
                    step_last = 1'b1;
                end
            endcase
        end

        if (do_push) begin
            gen = 1'b1;
            if (stack_full || nodes_full) begin
                gen_res = make_done('0, ST_OVERFLOW);
            end else begin
                gen_res = make_node(IDX_W'(r_next_node), 1'b1,
                                    VAL_W'(push_sym), '0, '0);
                n_top0.idx  = IDX_W'(r_next_node);
                n_top0.val  = VAL_W'(push_sym);
                n_top1      = r_top0;
                n_fwd       = r_top1;
                n_third_sel = 1'b0;
                n_count     = r_count + 1'b1;
                n_next_node = r_next_node + 1'b1;
                mem_we      = (r_count >= CNT_W'(2));
            end
        end

        if (do_comb) begin
            gen = 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_count = '0;
                gen_res = make_done(r_top0.idx, ST_OK);
            end else if (r_count == '0) begin
                gen_res = make_done('0, ST_UNDERFLOW);
            end else if (nodes_full) begin
                gen_res = make_done('0, ST_OVERFLOW);
            end else begin
                gen_res = make_node(IDX_W'(r_next_node), 1'b0, sum,
                                    r_top1.idx, r_top0.idx);
                n_top0.idx  = IDX_W'(r_next_node);
                n_top0.val  = sum;
                n_top1      = third;
                n_third_sel = 1'b1;
                mem_re      = 1'b1;
                n_count     = r_count - 1'b1;
                n_next_node = r_next_node + 1'b1;
            end
        end

        if (do_end) begin
            gen = 1'b1;
            if (r_bits_left != '0) begin
                gen_res = make_done('0, ST_INCOMPLETE);
            end else if (r_count == '0) begin
                gen_res = make_done('0, ST_EMPTY);
            end else if (r_count > CNT_W'(1)) begin
                gen_res = make_done('0, ST_LEFTOVER);
            end else begin
                n_count = '0;
                gen_res = make_done(r_top0.idx, ST_OK);
            end
        end

        // A finished header drops the rest of the current byte.
        if (gen && gen_res.header_done) begin
            n_finished = 1'b1;
            step_last  = 1'b1;
        end

        if (step_en) begin
            n_pos = step_last ? POS_MSB : r_pos - 1'b1;
        end
    end

    // The newest result is held back until it is known whether it is the
    // last word of its input word.
    always_comb begin
        o_res_push  = 1'b0;
        o_res_data  = r_pend;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_pend_last = r_pend_last;
        if (r_pend_v && !i_res_full &&
            (r_pend_last || (step_en && (gen || step_last)))) begin
            o_res_push             = 1'b1;
            o_res_data.last_result = r_pend_last || (step_en && step_last && !gen);
            n_pend_v               = 1'b0;
        end
        if (step_en && gen) begin
            n_pend      = gen_res;
            n_pend_v    = 1'b1;
            n_pend_last = step_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next_node <= '0;
            r_bits_left <= '0;
            r_shift     <= '0;
            r_finished  <= 1'b0;
            r_pos       <= POS_MSB;
            r_third_sel <= 1'b0;
            r_pend_v    <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_next_node <= n_next_node;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_finished  <= n_finished;
            r_pos       <= n_pos;
            r_third_sel <= n_third_sel;
            r_pend_v    <= n_pend_v;
            r_pend_last <= n_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top0 <= n_top0;
        r_top1 <= n_top1;
        r_fwd  <= n_fwd;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

endmodule
